FILE: design/uss_pkg.sv
`timescale 1ns / 1ps
package uss_pkg;

	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned SPEED_W = 32;
	localparam int unsigned BITS_W  = 4;
	localparam int unsigned MODE_W  = 2;
	localparam int unsigned TDATA_W = 48;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_ONE   = 8'h31;
	localparam logic [CHAR_W-1:0] CH_TWO   = 8'h32;
	localparam logic [CHAR_W-1:0] CH_FIVE  = 8'h35;
	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_N     = 8'h4E;
	localparam logic [CHAR_W-1:0] CH_E     = 8'h45;
	localparam logic [CHAR_W-1:0] CH_O     = 8'h4F;

	localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

	localparam logic [MODE_W-1:0] PAR_NONE = 2'd0;
	localparam logic [MODE_W-1:0] PAR_EVEN = 2'd1;
	localparam logic [MODE_W-1:0] PAR_ODD  = 2'd2;

	localparam logic [MODE_W-1:0] STOP_ONE      = 2'd0;
	localparam logic [MODE_W-1:0] STOP_ONE_HALF = 2'd1;
	localparam logic [MODE_W-1:0] STOP_TWO      = 2'd2;

	typedef enum logic [7:0] {
		PH_SPEED_FIRST = 8'b0000_0001,
		PH_SPEED       = 8'b0000_0010,
		PH_BITS        = 8'b0000_0100,
		PH_PARITY      = 8'b0000_1000,
		PH_STOP        = 8'b0001_0000,
		PH_STOP_ONE    = 8'b0010_0000,
		PH_STOP_DOT    = 8'b0100_0000,
		PH_DONE        = 8'b1000_0000
	} phase_t;

	typedef enum logic [2:0] {
		ERR_NONE   = 3'd0,
		ERR_SPEED  = 3'd1,
		ERR_BITS   = 3'd2,
		ERR_PARITY = 3'd3,
		ERR_STOP   = 3'd4
	} err_t;

	typedef struct packed {
		phase_t              phase;
		logic [SPEED_W-1:0]  speed;
		logic [BITS_W-1:0]   bits;
		logic [MODE_W-1:0]   parity;
		logic [MODE_W-1:0]   stop;
		err_t                err;
	} pstate_t;

	localparam pstate_t PSTATE_RESET = '{
		phase:  PH_SPEED_FIRST,
		speed:  '0,
		bits:   '0,
		parity: '0,
		stop:   '0,
		err:    ERR_NONE
	};

	typedef struct packed {
		logic [MODE_W-1:0]   stop_mode;
		logic [MODE_W-1:0]   parity_mode;
		logic [BITS_W-1:0]   data_bits;
		logic [SPEED_W-1:0]  baud_speed;
		err_t                error_code;
		logic                ok;
	} result_t;

endpackage

FILE: design/uart_settings_string_parser.sv
`timescale 1ns / 1ps
// a result word is offered on m_tvalid once the word carrying s_tlast has passed the
// input stage and been written into the result buffer
// throughput: one character word per cycle; a last word waits on a full result buffer
// reset: arst_n clears the input stage, the parse state and the two-entry result buffer
// at once; the parser also returns to its reset state after every string
module uart_settings_string_parser import uss_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// slave side: one character per word
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [CHAR_W-1:0]   s_tdata,   // [7:0] char_in
	input  logic                s_tlast,   // end_of_string
	// master side: one result word per string
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [TDATA_W-1:0]  m_tdata    // [0] ok, [3:1] error_code, [35:4] baud_speed,
	                                       // [39:36] data_bits, [41:40] parity_mode,
	                                       // [43:42] stop_mode, [47:44] zero
);

	// input stage
	logic               valid_s1;
	logic [CHAR_W-1:0]  char_s1;
	logic               last_s1;

	// parse state carried from character to character
	pstate_t            state_q;
	pstate_t            state_nxt;
	result_t            res;

	// result buffer handshake
	logic               buf_ready;
	logic               adv_s1;
	logic               push;
	result_t            buf_dout;

	// a last character waits in the input stage only when the result buffer is full
	assign adv_s1   = !last_s1 || buf_ready;
	assign s_tready = !valid_s1 || adv_s1;
	assign push     = valid_s1 && last_s1 && buf_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	uss_step u_step (
		.cur     (state_q),
		.char_in (char_s1),
		.nxt     (state_nxt),
		.res     (res)
	);

	// parse state: step on every character, back to reset after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PSTATE_RESET;
		end else if (valid_s1 && adv_s1) begin
			state_q <= last_s1 ? PSTATE_RESET : state_nxt;
		end
	end

	uss_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (res),
		.in_ready  (buf_ready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.dout      (buf_dout)
	);

	// pack fields from bit 0 up, zero pad to whole bytes
	assign m_tdata = {{(TDATA_W - $bits(result_t)){1'b0}}, buf_dout};

endmodule

FILE: design/uss_step.sv
`timescale 1ns / 1ps
module uss_step import uss_pkg::*; (
	input  pstate_t            cur,
	input  logic [CHAR_W-1:0]  char_in,
	output pstate_t            nxt,
	output result_t            res
);

	logic                 is_digit;
	logic [BITS_W-1:0]    digit;
	logic [SPEED_W+3:0]   prod;
	err_t                 fin_err;

	assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
	assign digit    = char_in[BITS_W-1:0];

	// speed * 10 + digit, 4 extra bits to catch overflow
	assign prod = {1'b0, cur.speed, 3'b000} + {3'b000, cur.speed, 1'b0}
		+ {{SPEED_W{1'b0}}, digit};

	always_comb begin
		nxt = cur;
		if (cur.err == ERR_NONE) begin
			unique case (cur.phase)
				PH_SPEED_FIRST: begin
					if (is_digit) begin
						nxt.speed = {{(SPEED_W-BITS_W){1'b0}}, digit};
						nxt.phase = PH_SPEED;
					end else begin
						nxt.err = ERR_SPEED;
					end
				end
				PH_SPEED: begin
					if (is_digit) begin
						nxt.speed = (prod[SPEED_W+3:SPEED_W] != 4'd0) ? SPEED_MAX
							: prod[SPEED_W-1:0];
					end else begin
						// separator byte is swallowed whatever it is
						nxt.phase = PH_BITS;
					end
				end
				PH_BITS: begin
					if (char_in != CH_SPACE) begin
						if (is_digit) begin
							nxt.bits  = digit;
							nxt.phase = PH_PARITY;
						end else begin
							nxt.err = ERR_BITS;
						end
					end
				end
				PH_PARITY: begin
					if (char_in == CH_N) begin
						nxt.parity = PAR_NONE;
						nxt.phase  = PH_STOP;
					end else if (char_in == CH_E) begin
						nxt.parity = PAR_EVEN;
						nxt.phase  = PH_STOP;
					end else if (char_in == CH_O) begin
						nxt.parity = PAR_ODD;
						nxt.phase  = PH_STOP;
					end else if (char_in != CH_SPACE) begin
						nxt.err = ERR_PARITY;
					end
				end
				PH_STOP: begin
					if (char_in == CH_ONE) begin
						nxt.stop  = STOP_ONE;
						nxt.phase = PH_STOP_ONE;
					end else if (char_in == CH_TWO) begin
						nxt.stop  = STOP_TWO;
						nxt.phase = PH_DONE;
					end else if (char_in != CH_SPACE) begin
						nxt.err = ERR_STOP;
					end
				end
				PH_STOP_ONE: begin
					if (char_in == CH_DOT) nxt.phase = PH_STOP_DOT;
					else                   nxt.err   = ERR_STOP;
				end
				PH_STOP_DOT: begin
					if (char_in == CH_FIVE) begin
						nxt.stop  = STOP_ONE_HALF;
						nxt.phase = PH_DONE;
					end else begin
						nxt.err = ERR_STOP;
					end
				end
				PH_DONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	// error implied by where the string ended
	always_comb begin
		fin_err = nxt.err;
		if (nxt.err == ERR_NONE) begin
			unique case (nxt.phase) inside
				PH_SPEED_FIRST:        fin_err = ERR_SPEED;
				PH_SPEED, PH_BITS:     fin_err = ERR_BITS;
				PH_PARITY:             fin_err = ERR_PARITY;
				PH_STOP, PH_STOP_DOT:  fin_err = ERR_STOP;
				default:               fin_err = ERR_NONE;
			endcase
		end
	end

	always_comb begin
		res.ok         = (fin_err == ERR_NONE);
		res.error_code = fin_err;
		res.baud_speed = res.ok ? nxt.speed  : '0;
		res.data_bits  = res.ok ? nxt.bits   : '0;
		res.parity_mode = res.ok ? nxt.parity : '0;
		res.stop_mode  = res.ok ? nxt.stop   : '0;
	end

endmodule

FILE: design/uss_out_buf.sv
`timescale 1ns / 1ps
module uss_out_buf import uss_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  result_t  din,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output result_t  dout
);

	result_t     head_q;
	result_t     tail_q;
	logic [1:0]  count_q;
	logic        pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign dout      = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		case (count_q)
			2'd0: begin
				if (push) head_q <= din;
			end
			2'd1: begin
				if (push && pop) head_q <= din;
				else if (push)   tail_q <= din;
			end
			2'd2: begin
				if (pop) head_q <= tail_q;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: design/uss_checker.sv
`timescale 1ns / 1ps
module uss_checker import uss_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tready,
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [TDATA_W-1:0]  m_tdata
);

	// stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// ok and error code agree
	a_ok_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[3:1] == 3'd0)
		else $error("ok result carries an error code");

	// failed result carries an error and zero fields
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[3:1] != 3'd0 && m_tdata[47:4] == 44'd0)
		else $error("failed result not cleared");

	// field ranges and padding
	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:36] <= 4'd9 && m_tdata[41:40] != 2'd3
			&& m_tdata[43:42] != 2'd3 && m_tdata[47:44] == 4'd0 && m_tdata[3:1] <= 3'd4)
		else $error("result field out of range");

	// an empty result buffer never holds off the input
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with no result pending");

endmodule

bind uart_settings_string_parser uss_checker u_uss_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: sim/tb.sv
`timescale 1ns / 1ps
module tb;
	import uss_pkg::*;

	localparam int RANDOM_WORDS   = 1700;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int DIR_ROWS       = 10;
	// in the directed text this character stands for a zero byte
	localparam byte ZERO_STAND_IN = "~";

	// receiver stall patterns
	typedef enum logic [1:0] {
		RDY_ALWAYS,
		RDY_COIN,
		RDY_SPARSE,
		RDY_BLOCKED
	} ready_mode_t;

	// one directed string, with its result typed in where it is obvious
	typedef struct {
		string   text;
		bit      typed;
		result_t want;
	} row_t;

	// per-string note pushed by the sender, consumed on the last word
	typedef struct packed {
		logic    typed;
		result_t want;
	} mark_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [CHAR_W-1:0]  s_tdata = '0;   // [7:0] char_in
	logic               s_tlast = 1'b0; // end_of_string
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;        // [0] ok, [3:1] error_code, [35:4] baud_speed,
	                                    // [39:36] data_bits, [41:40] parity_mode,
	                                    // [43:42] stop_mode, [47:44] zero

	uart_settings_string_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state, mirrors the parser
	phase_t             ph          = PH_SPEED_FIRST;
	logic [SPEED_W-1:0] acc_speed   = '0;
	logic [BITS_W-1:0]  held_bits   = '0;
	logic [MODE_W-1:0]  held_parity = PAR_NONE;
	logic [MODE_W-1:0]  held_stop   = STOP_ONE;
	err_t               held_err    = ERR_NONE;

	result_t            expected_results [$];
	mark_t              string_marks [$];
	logic [CHAR_W-1:0]  str_bytes [$];
	row_t               dir_rows [DIR_ROWS];

	int                 fail_cnt    = 0;
	int                 idle_cycles = 0;
	int                 words_sent  = 0;
	int                 burst_left  = 0;
	ready_mode_t        ready_mode  = RDY_ALWAYS;
	int                 ready_left  = 0;

	function automatic result_t fail_res(input err_t e);
		result_t r;
		r = '0;
		r.error_code = e;
		return r;
	endfunction

	function automatic result_t ok_res(input logic [SPEED_W-1:0] speed,
			input logic [BITS_W-1:0] bits, input logic [MODE_W-1:0] par,
			input logic [MODE_W-1:0] stop);
		return '{stop_mode: stop, parity_mode: par, data_bits: bits,
			baud_speed: speed, error_code: ERR_NONE, ok: 1'b1};
	endfunction

	// advance the predicted parser by one character; a result comes out on the last one
	task automatic parse_word(input logic [CHAR_W-1:0] ch, input logic last,
			output result_t res);
		logic [SPEED_W+3:0] wide;
		logic               is_digit;
		is_digit = ch inside {[CH_ZERO:CH_NINE]};
		res = '0;
		// a set error swallows the rest of the string
		if (held_err == ERR_NONE) begin
			case (ph)
			PH_SPEED_FIRST: begin
				if (is_digit) begin
					acc_speed = SPEED_W'(ch - CH_ZERO);
					ph = PH_SPEED;
				end else begin
					held_err = ERR_SPEED;
				end
			end
			PH_SPEED: begin
				// saturating times-ten accumulate, any non-digit is the separator
				if (is_digit) begin
					wide = (SPEED_W+4)'(acc_speed) * 10 + (SPEED_W+4)'(ch - CH_ZERO);
					acc_speed = (wide > (SPEED_W+4)'(SPEED_MAX)) ? SPEED_MAX : wide[SPEED_W-1:0];
				end else begin
					ph = PH_BITS;
				end
			end
			PH_BITS: begin
				if (is_digit) begin
					held_bits = BITS_W'(ch - CH_ZERO);
					ph = PH_PARITY;
				end else if (ch != CH_SPACE) begin
					held_err = ERR_BITS;
				end
			end
			PH_PARITY: begin
				if (ch == CH_N) begin
					held_parity = PAR_NONE;
					ph = PH_STOP;
				end else if (ch == CH_E) begin
					held_parity = PAR_EVEN;
					ph = PH_STOP;
				end else if (ch == CH_O) begin
					held_parity = PAR_ODD;
					ph = PH_STOP;
				end else if (ch != CH_SPACE) begin
					held_err = ERR_PARITY;
				end
			end
			PH_STOP: begin
				if (ch == CH_ONE) begin
					held_stop = STOP_ONE;
					ph = PH_STOP_ONE;
				end else if (ch == CH_TWO) begin
					held_stop = STOP_TWO;
					ph = PH_DONE;
				end else if (ch != CH_SPACE) begin
					held_err = ERR_STOP;
				end
			end
			PH_STOP_ONE: begin
				if (ch == CH_DOT) ph = PH_STOP_DOT;
				else held_err = ERR_STOP;
			end
			PH_STOP_DOT: begin
				if (ch == CH_FIVE) begin
					held_stop = STOP_ONE_HALF;
					ph = PH_DONE;
				end else begin
					held_err = ERR_STOP;
				end
			end
			default: ;
			endcase
		end
		if (last) begin
			// end of string: whatever field is still missing decides the error
			if (held_err == ERR_NONE) begin
				case (ph)
				PH_SPEED_FIRST:        held_err = ERR_SPEED;
				PH_SPEED, PH_BITS:     held_err = ERR_BITS;
				PH_PARITY:             held_err = ERR_PARITY;
				PH_STOP, PH_STOP_DOT:  held_err = ERR_STOP;
				default: ;
				endcase
			end
			res = (held_err == ERR_NONE) ?
				ok_res(acc_speed, held_bits, held_parity, held_stop) : fail_res(held_err);
			// parser starts over after every string
			ph          = PH_SPEED_FIRST;
			acc_speed   = '0;
			held_bits   = '0;
			held_parity = PAR_NONE;
			held_stop   = STOP_ONE;
			held_err    = ERR_NONE;
		end
	endtask

	task automatic check_field(input string name, input logic [SPEED_W-1:0] want,
			input logic [SPEED_W-1:0] got);
		if (want !== got) begin
			fail_cnt++;
			$display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	// one character word; the sender idles between bursts of random length
	task automatic send_word(input logic [CHAR_W-1:0] ch, input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			// a quarter of the bursts follow on with no gap at all
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		words_sent++;
	endtask

	// send str_bytes as one string, the last word flagged
	task automatic send_string(input bit typed, input result_t want);
		string_marks.push_back('{typed: typed, want: want});
		foreach (str_bytes[i]) send_word(str_bytes[i], i == str_bytes.size() - 1);
	endtask

	// receiver stalls on a pattern that changes mode now and then
	always @(posedge clk) begin
		if (ready_left == 0) begin
			ready_mode = ready_mode_t'($urandom_range(0, 3));
			ready_left = (ready_mode == RDY_BLOCKED) ? $urandom_range(5, 40) :
				$urandom_range(50, 400);
		end
		ready_left--;
		case (ready_mode)
		RDY_ALWAYS:  m_tready <= 1'b1;
		RDY_COIN:    m_tready <= 1'($urandom_range(0, 1));
		RDY_SPARSE:  m_tready <= ($urandom_range(0, 3) == 0);
		RDY_BLOCKED: m_tready <= 1'b0;
		endcase
	end

	// monitor: check result words, then predict from accepted character words
	always @(posedge clk) begin
		result_t got;
		result_t pred;
		mark_t   mark;
		if (arst_n) begin
			idle_cycles++;
			if (m_tvalid && m_tready) begin
				idle_cycles = 0;
				got = result_t'(m_tdata[$bits(result_t)-1:0]);
				if (expected_results.size() == 0) begin
					fail_cnt++;
					$display("%0t: unexpected result word: expected none actual %h",
						$time, m_tdata);
				end else begin
					pred = expected_results.pop_front();
					check_field("ok", pred.ok, got.ok);
					check_field("error_code", pred.error_code, got.error_code);
					check_field("baud_speed", pred.baud_speed, got.baud_speed);
					check_field("data_bits", pred.data_bits, got.data_bits);
					check_field("parity_mode", pred.parity_mode, got.parity_mode);
					check_field("stop_mode", pred.stop_mode, got.stop_mode);
					check_field("padding", '0, m_tdata[TDATA_W-1:$bits(result_t)]);
				end
			end
			if (s_tvalid && s_tready) begin
				idle_cycles = 0;
				parse_word(s_tdata, s_tlast, pred);
				if (s_tlast) begin
					mark = string_marks.pop_front();
					expected_results.push_back(mark.typed ? mark.want : pred);
				end
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		int          n;
		int          sel;
		logic [CHAR_W-1:0] ch;
		logic [CHAR_W-1:0] par_chars [3];
		string       sat_prefix;

		par_chars = '{CH_N, CH_E, CH_O};
		sat_prefix = "429496729";

		// directed strings
		dir_rows[0] = '{"x", 1'b1, fail_res(ERR_SPEED)};          // first byte not a digit
		dir_rows[1] = '{"5", 1'b1, fail_res(ERR_BITS)};           // end inside the speed
		// zero byte as separator, lowest speed, highest data bits
		dir_rows[2] = '{"0~9N1", 1'b1, ok_res('0, 4'd9, PAR_NONE, STOP_ONE)};
		// speed saturates, dot as separator, one and a half stop bits
		dir_rows[3] = '{"4294967296.0E1.5", 1'b1,
			ok_res(SPEED_MAX, 4'd0, PAR_EVEN, STOP_ONE_HALF)};
		dir_rows[4] = '{"7 8", 1'b1, fail_res(ERR_PARITY)};       // end before parity
		dir_rows[5] = '{"7 8O", 1'b1, fail_res(ERR_STOP)};        // end before stop field
		dir_rows[6] = '{"3 1E1.", 1'b1, fail_res(ERR_STOP)};      // end after "1."
		dir_rows[7] = '{"3 1E1x", 1'b1, fail_res(ERR_STOP)};      // '1' then junk
		dir_rows[8] = '{"12  8 O 2z", 1'b0, '0};                  // spaces, junk after stop
		dir_rows[9] = '{" 7", 1'b1, fail_res(ERR_SPEED)};         // error sticks

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			str_bytes.delete();
			for (int i = 0; i < dir_rows[r].text.len(); i++) begin
				ch = dir_rows[r].text[i];
				str_bytes.push_back(ch == ZERO_STAND_IN ? 8'h00 : ch);
			end
			send_string(dir_rows[r].typed, dir_rows[r].want);
		end

		// random strings: mostly well formed, some broken, some pure noise
		words_sent = 0;
		while (words_sent < RANDOM_WORDS) begin
			str_bytes.delete();
			sel = $urandom_range(0, 9);
			if (sel == 0) begin
				n = $urandom_range(1, 12);
				repeat (n) str_bytes.push_back(CHAR_W'($urandom_range(0, 255)));
			end else begin
				// speed: mostly short, sometimes long enough to saturate
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 7);
				if (n == 10 && $urandom_range(0, 1)) begin
					// right around the saturation point
					for (int i = 0; i < sat_prefix.len(); i++)
						str_bytes.push_back(sat_prefix[i]);
					str_bytes.push_back(CH_ZERO + CHAR_W'($urandom_range(4, 6)));
				end else begin
					repeat (n) str_bytes.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
				end
				// separator, any byte; a digit just lengthens the speed
				str_bytes.push_back(($urandom_range(0, 3) < 2) ? CH_SPACE :
					CHAR_W'($urandom_range(0, 255)));
				repeat ($urandom_range(0, 2)) str_bytes.push_back(CH_SPACE);
				str_bytes.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
				repeat ($urandom_range(0, 2)) str_bytes.push_back(CH_SPACE);
				str_bytes.push_back(par_chars[$urandom_range(0, 2)]);
				repeat ($urandom_range(0, 2)) str_bytes.push_back(CH_SPACE);
				case ($urandom_range(0, 2))
				0: str_bytes.push_back(CH_ONE);
				1: begin
					str_bytes.push_back(CH_ONE);
					str_bytes.push_back(CH_DOT);
					str_bytes.push_back(CH_FIVE);
				end
				default: str_bytes.push_back(CH_TWO);
				endcase
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 3))
						str_bytes.push_back(CHAR_W'($urandom_range(0, 255)));
				// break a few: corrupt one byte or cut the string short
				if (sel == 1) begin
					str_bytes[$urandom_range(0, str_bytes.size() - 1)] =
						CHAR_W'($urandom_range(0, 255));
				end else if (sel == 2) begin
					n = $urandom_range(1, str_bytes.size());
					while (str_bytes.size() > n) void'(str_bytes.pop_back());
				end
			end
			send_string(1'b0, '0);
		end
		s_tvalid <= 1'b0;

		// drain, then let the block run on idle and check that nothing is left pending
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_results.size() != 0 || string_marks.size() != 0) begin
			fail_cnt++;
			$display("%0t: results still pending: expected %0d actual 0", $time,
				expected_results.size());
		end

		if (fail_cnt == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: filelist.f
design/uss_pkg.sv
design/uss_step.sv
design/uss_out_buf.sv
design/uart_settings_string_parser.sv
design/uss_checker.sv
sim/tb.sv
